FILE: hdl/assert_macros.svh
// assertion macros for the formatter, included by the encode stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/bfd_pkg.sv
// shared constants and types of the fixed-point to decimal formatter
package bfd_pkg;

    localparam logic [31:0] LIMIT_VALUE = 32'd64000;

    localparam logic [5:0] CH_SPACE = 6'd32;
    localparam logic [5:0] CH_STAR  = 6'd42;
    localparam logic [5:0] CH_POINT = 6'd46;
    localparam logic [5:0] CH_ZERO  = 6'd48;

    // hundredths count is below 2^17; the top three bits need no correction
    localparam int Q_W        = 17;
    localparam int PRE_BITS   = 3;
    localparam int BIN_W      = Q_W - PRE_BITS;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DD_STEPS   = BIN_W / 2;

    typedef struct packed {
        logic               ovf;
        logic [BCD_W-1:0]   bcd;
        logic [BIN_W-1:0]   bin;
    } dd_word_t;

endpackage

FILE: hdl/bfd_scale.sv
// first stage: range check and scaling to rounded hundredths
module bfd_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  logic [31:0]       value,
    output logic              dn_valid,
    input  logic              dn_stall,
    output bfd_pkg::dd_word_t dn_word
);
    import bfd_pkg::*;

    logic     valid_reg;
    dd_word_t word_reg;
    dd_word_t word_next;
    logic     ready;
    logic [15:0]    v16;
    logic [20:0]    sum;
    logic [Q_W-1:0] q;

    // rounded hundredths = floor((25 * value + 8) / 16)
    always_comb
    begin
        v16 = value[15:0];
        sum = ({5'd0, v16} << 4) + ({5'd0, v16} << 3) + {5'd0, v16} + 21'd8;
        q   = sum[20:4];
        word_next.ovf = (value >= LIMIT_VALUE);
        word_next.bcd = {{(BCD_W-PRE_BITS){1'b0}}, q[Q_W-1 -: PRE_BITS]};
        word_next.bin = q[BIN_W-1:0];
    end

    assign ready    = !valid_reg || !dn_stall;
    assign stall    = !ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hdl/bfd_dabble.sv
// one stage of the binary to bcd conversion, a fixed number of shift-add-3 steps
module bfd_dabble (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  bfd_pkg::dd_word_t up_word,
    output logic              dn_valid,
    input  logic              dn_stall,
    output bfd_pkg::dd_word_t dn_word
);
    import bfd_pkg::*;

    logic     valid_reg;
    dd_word_t word_reg;
    dd_word_t word_next;
    logic     ready;

    always_comb
    begin
        logic [BCD_W+BIN_W-1:0] acc;
        logic [3:0]             dig;
        acc = {up_word.bcd, up_word.bin};
        dig = 4'd0;
        for (int s = 0; s < DD_STEPS; s++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                dig = acc[BIN_W + 4*k +: 4];
                if (dig >= 4'd5)
                begin
                    acc[BIN_W + 4*k +: 4] = dig + 4'd3;
                end
            end
            acc = acc << 1;
        end
        word_next.ovf = up_word.ovf;
        word_next.bcd = acc[BCD_W+BIN_W-1:BIN_W];
        word_next.bin = acc[BIN_W-1:0];
    end

    assign ready    = !valid_reg || !dn_stall;
    assign up_stall = !ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hdl/bfd_encode.sv
// last stage: digits to ascii with blanking and the overflow pattern
`include "assert_macros.svh"

module bfd_encode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  bfd_pkg::dd_word_t up_word,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [5:0]        char_hundreds,
    output logic [5:0]        char_tens,
    output logic [5:0]        char_ones,
    output logic [5:0]        char_point,
    output logic [5:0]        char_tenths,
    output logic [5:0]        char_hundredths,
    output logic              overflow
);
    import bfd_pkg::*;

    logic       valid_reg;
    logic       ready;
    logic [5:0] hund_reg, tens_reg, ones_reg, tenths_reg, hundredths_reg;
    logic [5:0] hund_next, tens_next, ones_next, tenths_next, hundredths_next;
    logic       ovf_reg;
    logic [3:0] d4, d3, d2, d1, d0;

    always_comb
    begin
        d4 = up_word.bcd[19:16];
        d3 = up_word.bcd[15:12];
        d2 = up_word.bcd[11:8];
        d1 = up_word.bcd[7:4];
        d0 = up_word.bcd[3:0];
        if (up_word.ovf)
        begin
            hund_next       = CH_STAR;
            tens_next       = CH_STAR;
            ones_next       = CH_STAR;
            tenths_next     = CH_STAR;
            hundredths_next = CH_STAR;
        end
        else
        begin
            hund_next       = (d4 != 4'd0) ? (CH_ZERO | {2'd0, d4}) : CH_SPACE;
            tens_next       = (d4 != 4'd0 || d3 != 4'd0) ? (CH_ZERO | {2'd0, d3}) : CH_SPACE;
            ones_next       = CH_ZERO | {2'd0, d2};
            tenths_next     = CH_ZERO | {2'd0, d1};
            hundredths_next = CH_ZERO | {2'd0, d0};
        end
    end

    assign ready           = !valid_reg || !result_stall;
    assign up_stall        = !ready;
    assign result_valid    = valid_reg;
    assign char_hundreds   = hund_reg;
    assign char_tens       = tens_reg;
    assign char_ones       = ones_reg;
    assign char_point      = CH_POINT;
    assign char_tenths     = tenths_reg;
    assign char_hundredths = hundredths_reg;
    assign overflow        = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            hund_reg       <= hund_next;
            tens_reg       <= tens_next;
            ones_reg       <= ones_next;
            tenths_reg     <= tenths_next;
            hundredths_reg <= hundredths_next;
            ovf_reg        <= up_word.ovf;
        end
    end

    // the ones place of a converted word must hold a decimal digit; an overflow word shows stars
    `BFD_ASSERT_IMP(a_ones_digit, clk, rst_n, result_valid && !overflow, (char_ones >= CH_ZERO) && (char_ones <= (CH_ZERO + 6'd9)))
    `BFD_ASSERT_IMP(a_ovf_stars, clk, rst_n, result_valid && overflow, (char_hundreds == CH_STAR) && (char_hundredths == CH_STAR))
    // tens blanks only under a blank hundreds place
    `BFD_ASSERT_IMP(a_blank_order, clk, rst_n, result_valid && (char_tens == CH_SPACE), char_hundreds == CH_SPACE)
    `BFD_ASSERT_NEXT(a_take_word, clk, rst_n, up_valid && !up_stall, result_valid)

endmodule

FILE: hdl/binary_fixed_decimal_formatter_top.sv
// Unsigned 1/64 fixed-point to six ASCII characters "ddd.dd", rounded half up at the
// thousandths; leading zeros of the hundreds and tens places show as spaces, and a value
// of 64000 or more shows "***.**" with overflow set. One word is taken every cycle while
// the input is not stalled, and its result passes through four register stages: a
// scaling stage, two binary to bcd stages of seven shift-add-3 steps each, and the
// character output register. Stall on the result side backs up stage by stage; the
// input stalls only when every stage holds a word and the result side stalls.
module binary_fixed_decimal_formatter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [31:0] value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [5:0]  char_hundreds,
    output logic [5:0]  char_tens,
    output logic [5:0]  char_ones,
    output logic [5:0]  char_point,
    output logic [5:0]  char_tenths,
    output logic [5:0]  char_hundredths,
    output logic        overflow
);
    import bfd_pkg::*;

    logic     s1_valid, s1_stall;
    logic     s2_valid, s2_stall;
    logic     s3_valid, s3_stall;
    dd_word_t s1_word, s2_word, s3_word;

    bfd_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid),
        .stall    (stall),
        .value    (value),
        .dn_valid (s1_valid),
        .dn_stall (s1_stall),
        .dn_word  (s1_word)
    );

    bfd_dabble u_dabble_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_word  (s1_word),
        .dn_valid (s2_valid),
        .dn_stall (s2_stall),
        .dn_word  (s2_word)
    );

    bfd_dabble u_dabble_lo (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_stall (s2_stall),
        .up_word  (s2_word),
        .dn_valid (s3_valid),
        .dn_stall (s3_stall),
        .dn_word  (s3_word)
    );

    bfd_encode u_encode (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (s3_valid),
        .up_stall        (s3_stall),
        .up_word         (s3_word),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .char_hundreds   (char_hundreds),
        .char_tens       (char_tens),
        .char_ones       (char_ones),
        .char_point      (char_point),
        .char_tenths     (char_tenths),
        .char_hundredths (char_hundredths),
        .overflow        (overflow)
    );

endmodule
